// ----- src/mi3_pkg.sv -----
`default_nettype none
package mi3_pkg;

	localparam int VALUE_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int N_ELEM         = 9;
	localparam int IDX_BITS       = 4;
	localparam int STEP_BITS      = 5;
	localparam int N_CROSS        = 10;

	localparam logic [IDX_BITS-1:0]  LAST_IDX  = 4'd8;
	localparam logic [STEP_BITS-1:0] LAST_STEP = 5'd22;

	// operand sources above the matrix entries
	localparam logic [3:0] SRC_CR0 = 4'd9;
	localparam logic [3:0] SRC_CR6 = 4'd10;
	localparam logic [3:0] SRC_CR9 = 4'd11;

	typedef enum logic [1:0] {
		OP_LOAD,
		OP_CROSS,
		OP_SUB,
		OP_ADD
	} mul_op_t;

	typedef struct packed {
		logic [3:0] src_a;
		logic [3:0] src_b;
		mul_op_t    op;
	} mul_sel_t;

	// product schedule: ten 2x2 minors, then the first-row expansion
	function automatic mul_sel_t mul_sel(input logic [STEP_BITS-1:0] step);
		mul_sel_t s;
		s.op = step[0] ? OP_CROSS : OP_LOAD;
		case (step)
			5'd0:  begin s.src_a = 4'd4; s.src_b = 4'd8; end
			5'd1:  begin s.src_a = 4'd5; s.src_b = 4'd7; end
			5'd2:  begin s.src_a = 4'd2; s.src_b = 4'd7; end
			5'd3:  begin s.src_a = 4'd1; s.src_b = 4'd8; end
			5'd4:  begin s.src_a = 4'd1; s.src_b = 4'd5; end
			5'd5:  begin s.src_a = 4'd2; s.src_b = 4'd4; end
			5'd6:  begin s.src_a = 4'd5; s.src_b = 4'd6; end
			5'd7:  begin s.src_a = 4'd3; s.src_b = 4'd8; end
			5'd8:  begin s.src_a = 4'd0; s.src_b = 4'd8; end
			5'd9:  begin s.src_a = 4'd2; s.src_b = 4'd6; end
			5'd10: begin s.src_a = 4'd2; s.src_b = 4'd3; end
			5'd11: begin s.src_a = 4'd0; s.src_b = 4'd5; end
			5'd12: begin s.src_a = 4'd3; s.src_b = 4'd7; end
			5'd13: begin s.src_a = 4'd4; s.src_b = 4'd6; end
			5'd14: begin s.src_a = 4'd1; s.src_b = 4'd6; end
			5'd15: begin s.src_a = 4'd0; s.src_b = 4'd7; end
			5'd16: begin s.src_a = 4'd0; s.src_b = 4'd4; end
			5'd17: begin s.src_a = 4'd1; s.src_b = 4'd3; end
			5'd18: begin s.src_a = 4'd3; s.src_b = 4'd8; end
			5'd19: begin s.src_a = 4'd5; s.src_b = 4'd6; end
			5'd20: begin s.src_a = 4'd0; s.src_b = SRC_CR0; s.op = OP_LOAD; end
			5'd21: begin s.src_a = 4'd1; s.src_b = SRC_CR9; s.op = OP_SUB; end
			5'd22: begin s.src_a = 4'd2; s.src_b = SRC_CR6; s.op = OP_ADD; end
			default: begin s.src_a = 4'd0; s.src_b = 4'd0; s.op = OP_LOAD; end
		endcase
		return s;
	endfunction

endpackage
`default_nettype wire

// ----- src/mi3_front.sv -----
`default_nettype none
module mi3_front #(
	parameter int VALUE_BITS = mi3_pkg::VALUE_BITS_DEF
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    push,
	output logic                                         full,
	input  wire logic [mi3_pkg::IDX_BITS-1:0]            elem_index,
	input  wire logic signed [VALUE_BITS-1:0]            elem_value,
	input  wire logic                                    start_invert,
	output logic                                         job_valid,
	input  wire logic                                    job_pop,
	output logic [mi3_pkg::N_ELEM*VALUE_BITS-1:0]        job_mat
);

	localparam int MW = mi3_pkg::N_ELEM * VALUE_BITS;

	logic signed [VALUE_BITS-1:0] store_q [mi3_pkg::N_ELEM];
	logic signed [VALUE_BITS-1:0] store_nx [mi3_pkg::N_ELEM];
	logic [MW-1:0] snap;
	logic [MW-1:0] jq_q [2];
	logic          wp_q, rp_q;
	logic [1:0]    cnt_q;
	logic          acc, jpush, jpop;

	assign full      = (cnt_q == 2'd2);
	assign acc       = push && !full;
	assign jpush     = acc && start_invert;
	assign jpop      = job_pop && job_valid;
	assign job_valid = (cnt_q != 2'd0);
	assign job_mat   = jq_q[rp_q];

	always_comb begin
		for (int i = 0; i < mi3_pkg::N_ELEM; i++) begin
			store_nx[i] = store_q[i];
			if (elem_index == 4'(i)) store_nx[i] = elem_value;
			snap[i*VALUE_BITS +: VALUE_BITS] = store_nx[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mi3_pkg::N_ELEM; i++) store_q[i] <= '0;
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (acc) begin
				for (int i = 0; i < mi3_pkg::N_ELEM; i++) store_q[i] <= store_nx[i];
			end
			if (jpush) wp_q <= !wp_q;
			if (jpop) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(jpush) - 2'(jpop);
		end
	end

	always_ff @(posedge clk) begin
		if (jpush) jq_q[wp_q] <= snap;
	end

endmodule
`default_nettype wire

// ----- src/mi3_back.sv -----
`default_nettype none
module mi3_back #(
	parameter int VALUE_BITS = mi3_pkg::VALUE_BITS_DEF,
	parameter int FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                         clk,
	input  wire logic                                         arst_n,
	input  wire logic                                         job_valid,
	output logic                                              job_pop,
	input  wire logic [mi3_pkg::N_ELEM*VALUE_BITS-1:0]        job_mat,
	output logic                                              res_push,
	input  wire logic                                         res_full,
	output logic [mi3_pkg::IDX_BITS+2*VALUE_BITS+1:0]         res_data
);

	localparam int VB = VALUE_BITS;
	localparam int NW = VALUE_BITS + FRAC_BITS;
	localparam int CW = $clog2(NW);
	localparam logic signed [VB-1:0] VMAX = {1'b0, {(VB-1){1'b1}}};
	localparam logic signed [VB-1:0] VMIN = {1'b1, {(VB-1){1'b0}}};
	localparam logic [2*VB-1:0] FMASK = {{(2*VB-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_A,
		ST_MUL_B,
		ST_DIV_INIT,
		ST_DIV,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic signed [VB-1:0] mat_q [mi3_pkg::N_ELEM];
	logic signed [VB-1:0] cr_q [mi3_pkg::N_CROSS];
	logic signed [VB-1:0] acc_q, res_val_q;
	logic signed [2*VB-1:0] prod_q;
	logic [mi3_pkg::STEP_BITS-1:0] p_q;
	logic [mi3_pkg::IDX_BITS-1:0] k_q;
	logic [NW-1:0] num_q, quo_q;
	logic [VB-1:0] rem_q, dm_q;
	logic [CW-1:0] cnt_q;
	logic neg_q, sing_q;

	mi3_pkg::mul_sel_t sel;
	logic signed [VB-1:0] opa, opb, psat, asat, crk;
	logic signed [2*VB-1:0] padj, psh;
	logic signed [VB:0] sum;
	logic [VB:0] remsh, remdf;
	logic ge;
	logic [NW-1:0] qn, limw, qs;
	logic [VB-1:0] qv;

	assign sel = mi3_pkg::mul_sel(p_q);
	assign crk = cr_q[k_q];

	always_comb begin
		if (sel.src_a < 4'd9) opa = mat_q[sel.src_a];
		else opa = cr_q[0];
		case (sel.src_b)
			mi3_pkg::SRC_CR0: opb = cr_q[0];
			mi3_pkg::SRC_CR6: opb = cr_q[6];
			mi3_pkg::SRC_CR9: opb = cr_q[9];
			default: opb = (sel.src_b < 4'd9) ? mat_q[sel.src_b] : cr_q[9];
		endcase
	end

	// product, truncated toward zero, saturated
	always_comb begin
		padj = prod_q + (prod_q[2*VB-1] ? FMASK : '0);
		psh  = padj >>> FRAC_BITS;
		if ((&psh[2*VB-1:VB-1]) || !(|psh[2*VB-1:VB-1])) psat = psh[VB-1:0];
		else psat = psh[2*VB-1] ? VMIN : VMAX;
		if (sel.op == mi3_pkg::OP_ADD) sum = {acc_q[VB-1], acc_q} + {psat[VB-1], psat};
		else sum = {acc_q[VB-1], acc_q} - {psat[VB-1], psat};
		if (sum[VB] != sum[VB-1]) asat = sum[VB] ? VMIN : VMAX;
		else asat = sum[VB-1:0];
	end

	// restoring divider, one quotient bit per cycle
	always_comb begin
		remsh = {rem_q, num_q[NW-1]};
		ge    = remsh >= {1'b0, dm_q};
		remdf = ge ? remsh - {1'b0, dm_q} : remsh;
		qn    = {quo_q[NW-2:0], ge};
		limw  = {{(NW-VB){1'b0}}, neg_q, {(VB-1){!neg_q}}};
		qs    = (qn > limw) ? limw : qn;
		qv    = qs[VB-1:0];
	end

	assign job_pop  = (state_q == ST_IDLE) && job_valid;
	assign res_push = (state_q == ST_EMIT) && !res_full;
	assign res_data = {k_q, res_val_q, acc_q, sing_q, k_q == mi3_pkg::LAST_IDX};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			p_q     <= '0;
			k_q     <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						p_q     <= '0;
						state_q <= ST_MUL_A;
					end
				end
				ST_MUL_A: state_q <= ST_MUL_B;
				ST_MUL_B: begin
					p_q <= p_q + 1'b1;
					if (p_q == mi3_pkg::LAST_STEP) begin
						k_q     <= '0;
						state_q <= ST_DIV_INIT;
					end else begin
						state_q <= ST_MUL_A;
					end
				end
				ST_DIV_INIT: begin
					cnt_q   <= '0;
					state_q <= (acc_q == '0) ? ST_EMIT : ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(NW-1)) state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!res_full) begin
						if (k_q == mi3_pkg::LAST_IDX) begin
							state_q <= ST_IDLE;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= ST_DIV_INIT;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			for (int i = 0; i < mi3_pkg::N_ELEM; i++)
				mat_q[i] <= job_mat[i*VB +: VB];
		end
		if (state_q == ST_MUL_A) prod_q <= opa * opb;
		if (state_q == ST_MUL_B) begin
			case (sel.op)
				mi3_pkg::OP_LOAD:  acc_q <= psat;
				mi3_pkg::OP_CROSS: cr_q[p_q[4:1]] <= asat;
				mi3_pkg::OP_SUB:   acc_q <= asat;
				mi3_pkg::OP_ADD:   acc_q <= asat;
				default:           acc_q <= psat;
			endcase
		end
		if (state_q == ST_DIV_INIT) begin
			sing_q    <= (acc_q == '0);
			res_val_q <= mat_q[k_q];
			num_q     <= {(crk[VB-1] ? -crk : crk), {FRAC_BITS{1'b0}}};
			dm_q      <= acc_q[VB-1] ? -acc_q : acc_q;
			neg_q     <= crk[VB-1] ^ acc_q[VB-1];
			rem_q     <= '0;
			quo_q     <= '0;
		end
		if (state_q == ST_DIV) begin
			rem_q <= remdf[VB-1:0];
			quo_q <= qn;
			num_q <= {num_q[NW-2:0], 1'b0};
			if (cnt_q == CW'(NW-1)) res_val_q <= neg_q ? -qv : qv;
		end
	end

endmodule
`default_nettype wire

// ----- src/mi3_res_fifo.sv -----
`default_nettype none
module mi3_res_fifo #(
	parameter int WIDTH = 2 * mi3_pkg::VALUE_BITS_DEF + mi3_pkg::IDX_BITS + 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr,
	output logic                  full,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             rd,
	output logic                  empty,
	output logic [WIDTH-1:0]      rdata
);

	logic [WIDTH-1:0] buf_q [2];
	logic             wp_q, rp_q;
	logic [1:0]       cnt_q;
	logic             we, re;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign we    = wr && !full;
	assign re    = rd && !empty;
	assign rdata = buf_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (we) wp_q <= !wp_q;
			if (re) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(we) - 2'(re);
		end
	end

	always_ff @(posedge clk) begin
		if (we) buf_q[wp_q] <= wdata;
	end

endmodule
`default_nettype wire

// ----- src/matrix_inverse_3x3.sv -----
// channel   ports                                          transaction
// input     push, full, elem_index, elem_value,            push && !full
//           start_invert
// result    empty, pop, out_index, out_value,              pop && !empty
//           determinant, singular, last_result
//
// a load is taken when full is low; a two-entry job queue holds matrices awaiting inversion
// an inversion first forms 23 products on the shared multiplier, each in ST_MUL_A then ST_MUL_B;
// each entry then passes through ST_DIV_INIT, the bit-serial divider in ST_DIV and ST_EMIT,
// but a singular matrix skips the divider and goes from ST_DIV_INIT straight to ST_EMIT
// arst_n clears the element store and all queues; a full result queue holds the back end in ST_EMIT
`default_nettype none
module matrix_inverse_3x3 #(
	parameter int VALUE_BITS = mi3_pkg::VALUE_BITS_DEF,
	parameter int FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                push,
	output logic                                     full,
	input  wire logic [mi3_pkg::IDX_BITS-1:0]        elem_index,
	input  wire logic signed [VALUE_BITS-1:0]        elem_value,
	input  wire logic                                start_invert,
	output logic                                     empty,
	input  wire logic                                pop,
	output logic [mi3_pkg::IDX_BITS-1:0]             out_index,
	output logic signed [VALUE_BITS-1:0]             out_value,
	output logic signed [VALUE_BITS-1:0]             determinant,
	output logic                                     singular,
	output logic                                     last_result
);

	localparam int RW = mi3_pkg::IDX_BITS + 2 * VALUE_BITS + 2;

	logic                                     job_valid, job_pop;
	logic [mi3_pkg::N_ELEM*VALUE_BITS-1:0]    job_mat;
	logic                                     res_push, res_full;
	logic [RW-1:0]                            res_data, res_q;

	mi3_front #(.VALUE_BITS(VALUE_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.elem_index(elem_index), .elem_value(elem_value), .start_invert(start_invert),
		.job_valid(job_valid), .job_pop(job_pop), .job_mat(job_mat)
	);

	mi3_back #(.VALUE_BITS(VALUE_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(job_valid), .job_pop(job_pop),
		.job_mat(job_mat), .res_push(res_push), .res_full(res_full), .res_data(res_data)
	);

	mi3_res_fifo #(.WIDTH(RW)) u_res (
		.clk(clk), .arst_n(arst_n), .wr(res_push), .full(res_full), .wdata(res_data),
		.rd(pop), .empty(empty), .rdata(res_q)
	);

	assign {out_index, out_value, determinant, singular, last_result} = res_q;

	a_sing_det: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (singular == (determinant == '0)))
		else $error("singular flag disagrees with determinant");

	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (last_result == (out_index == mi3_pkg::LAST_IDX)))
		else $error("last result not on final index");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (out_index <= mi3_pkg::LAST_IDX))
		else $error("result index out of range");

endmodule
`default_nettype wire

// ----- sim/matrix_inverse_3x3_tb.sv -----
`timescale 1ns / 1ps
module matrix_inverse_3x3_tb;

	localparam int VB = mi3_pkg::VALUE_BITS_DEF;
	localparam int FB = mi3_pkg::FRAC_BITS_DEF;
	localparam int IB = mi3_pkg::IDX_BITS;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int SETTLE_CYCLES = 600;
	localparam logic signed [VB-1:0] ONE = 1 <<< FB;

	class inv_scoreboard;
		typedef struct {
			logic [IB-1:0] idx;
			logic signed [VB-1:0] val;
			logic signed [VB-1:0] det;
			logic sing;
			logic last;
		} inv_entry_t;

		longint mtx[9];
		inv_entry_t pending[$];
		int errors;

		function new();
			foreach (mtx[i]) mtx[i] = 0;
			errors = 0;
		endfunction

		function longint clamp(longint v);
			longint vmax;
			longint vmin;
			vmax = (longint'(1) <<< (VB - 1)) - 1;
			vmin = -vmax - 1;
			if (v > vmax) return vmax;
			if (v < vmin) return vmin;
			return v;
		endfunction

		// product truncated toward zero
		function longint fx_mul(longint a, longint b);
			longint p;
			p = a * b;
			return clamp(p / (longint'(1) <<< FB));
		endfunction

		function longint minor(longint p, longint q, longint r, longint s);
			return clamp(fx_mul(p, q) - fx_mul(r, s));
		endfunction

		function void note_load(logic [IB-1:0] idx, logic signed [VB-1:0] val, logic st);
			longint adj[9];
			longint det;
			longint v;
			inv_entry_t e;
			if (idx < 9) mtx[idx] = val;
			if (!st) return;
			adj[0] = minor(mtx[4], mtx[8], mtx[5], mtx[7]);
			adj[1] = minor(mtx[2], mtx[7], mtx[1], mtx[8]);
			adj[2] = minor(mtx[1], mtx[5], mtx[2], mtx[4]);
			adj[3] = minor(mtx[5], mtx[6], mtx[3], mtx[8]);
			adj[4] = minor(mtx[0], mtx[8], mtx[2], mtx[6]);
			adj[5] = minor(mtx[2], mtx[3], mtx[0], mtx[5]);
			adj[6] = minor(mtx[3], mtx[7], mtx[4], mtx[6]);
			adj[7] = minor(mtx[1], mtx[6], mtx[0], mtx[7]);
			adj[8] = minor(mtx[0], mtx[4], mtx[1], mtx[3]);
			det = fx_mul(mtx[0], adj[0]);
			det = clamp(det - fx_mul(mtx[1], minor(mtx[3], mtx[8], mtx[5], mtx[6])));
			det = clamp(det + fx_mul(mtx[2], adj[6]));
			for (int k = 0; k < 9; k++) begin
				if (det == 0) v = mtx[k];
				else v = clamp((adj[k] * (longint'(1) <<< FB)) / det);
				e.idx = IB'(k);
				e.val = v[VB-1:0];
				e.det = det[VB-1:0];
				e.sing = (det == 0);
				e.last = (k == 8);
				pending.push_back(e);
			end
		endfunction

		function void check_result(logic [IB-1:0] idx, logic signed [VB-1:0] val,
			logic signed [VB-1:0] det, logic sing, logic last);
			inv_entry_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: index %0d value %h det %h", idx, val, det);
				return;
			end
			e = pending.pop_front();
			if (idx !== e.idx || val !== e.val || det !== e.det || sing !== e.sing
				|| last !== e.last) begin
				errors++;
				if (errors <= 10)
					$display({"mismatch: exp idx %0d val %h det %h sing %b last %b",
						" / got idx %0d val %h det %h sing %b last %b"},
						e.idx, e.val, e.det, e.sing, e.last, idx, val, det, sing, last);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	logic [IB-1:0] elem_index;
	logic signed [VB-1:0] elem_value;
	logic start_invert;
	logic empty;
	logic pop;
	logic [IB-1:0] out_index;
	logic signed [VB-1:0] out_value;
	logic signed [VB-1:0] determinant;
	logic singular;
	logic last_result;

	inv_scoreboard sb;
	int send_idle_pct;
	int pop_stall_pct;
	int cycles;

	matrix_inverse_3x3 u_top (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.elem_index(elem_index),
		.elem_value(elem_value),
		.start_invert(start_invert),
		.empty(empty),
		.pop(pop),
		.out_index(out_index),
		.out_value(out_value),
		.determinant(determinant),
		.singular(singular),
		.last_result(last_result)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (!arst_n) pop <= 1'b0;
		else pop <= ($urandom_range(99) >= pop_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			sb.check_result(out_index, out_value, determinant, singular, last_result);
	end

	// called at a falling edge, returns at a falling edge with push still high
	task automatic send(logic [IB-1:0] idx, logic signed [VB-1:0] val, logic st);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		elem_index <= idx;
		elem_value <= val;
		start_invert <= st;
		@(posedge clk);
		while (full) @(posedge clk);
		sb.note_load(idx, val, st);
		@(negedge clk);
	endtask

	function automatic logic signed [VB-1:0] rand_value(int kind);
		case (kind)
			0: return $signed($urandom_range(2 * 524288)) - 524288;
			1: return $urandom();
			2: return $signed($urandom_range(8)) - 4;
			default: return $urandom_range(3) == 0 ? ONE : $signed($urandom_range(131072)) - 65536;
		endcase
	endfunction

	// whole matrix in random order, start on the last transaction
	task automatic send_matrix(int kind);
		int order[9];
		int j;
		int t;
		logic signed [VB-1:0] vals[9];
		foreach (order[i]) order[i] = i;
		for (int i = 8; i > 0; i--) begin
			j = $urandom_range(i);
			t = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		foreach (vals[i]) vals[i] = rand_value(kind);
		// dependent row gives a singular matrix
		if ($urandom_range(5) == 0)
			for (int c = 0; c < 3; c++) vals[6 + c] = vals[c];
		for (int i = 0; i < 9; i++)
			send(IB'(order[i]), vals[order[i]], i == 8);
	endtask

	task automatic random_phase(int n_items);
		int sent;
		int r;
		int k;
		sent = 0;
		while (sent < n_items) begin
			r = $urandom_range(9);
			if (r < 7) begin
				send_matrix($urandom_range(3));
				sent += 9;
			end else if (r < 9) begin
				k = $urandom_range(1, 4);
				for (int i = 0; i < k; i++)
					send(IB'($urandom_range(8)), rand_value($urandom_range(3)), i == k - 1);
				sent += k;
			end else begin
				send(IB'($urandom_range(15)), $urandom(), $urandom_range(3) == 0);
				sent += 1;
			end
		end
	endtask

	initial begin
		sb = new();
		cycles = 0;
		send_idle_pct = 0;
		pop_stall_pct = 0;
		arst_n = 1'b0;
		push = 1'b0;
		elem_index = '0;
		elem_value = '0;
		start_invert = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// cleared store, index out of range is not stored
		send(4'd9, ONE, 1'b1);
		send(4'd15, 32'h7fffffff, 1'b1);
		// identity
		send(4'd0, ONE, 1'b0);
		send(4'd4, ONE, 1'b0);
		send(4'd8, ONE, 1'b1);
		// scaled diagonal, no start on off-range noise
		send(4'd4, 2 * ONE, 1'b0);
		send(4'd12, 32'h80000000, 1'b0);
		send(4'd8, -ONE / 2, 1'b1);
		// extremes saturate
		send(4'd0, 32'h7fffffff, 1'b0);
		send(4'd4, 32'h80000000, 1'b0);
		send(4'd8, 32'h7fffffff, 1'b1);
		send(4'd1, 32'h80000000, 1'b0);
		send(4'd2, 32'h7fffffff, 1'b0);
		send(4'd3, 32'hffffffff, 1'b1);
		// determinant truncating to zero
		for (int i = 0; i < 9; i++) send(IB'(i), (i % 4 == 0) ? 32'sd1 : 32'sd0, i == 8);

		random_phase(110);
		send_idle_pct = 64;
		random_phase(110);
		send_idle_pct = 0;
		pop_stall_pct = 64;
		random_phase(110);
		send_idle_pct = 11;
		pop_stall_pct = 11;
		random_phase(110);
		push <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
src/mi3_pkg.sv
src/mi3_front.sv
src/mi3_back.sv
src/mi3_res_fifo.sv
src/matrix_inverse_3x3.sv
sim/matrix_inverse_3x3_tb.sv
